>>> sv/hfnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfnm_pkg
// Shared types and constants for the neighbor median hole fill pipeline.
// ----------------------------------------------------------------------------
package hfnm_pkg;

  localparam int PIX_W  = 24;
  localparam int BLUE_W = 8;
  localparam int NBR_N  = 8;
  localparam int CNT_W  = 4;
  localparam int RANK_W = 3;
  localparam int MIN_W  = 4;

  localparam logic [MIN_W-1:0] MIN_RESET = 4'd1;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [BLUE_W-1:0] blue_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [MIN_W-1:0]  min_t;

  // Neighbors in scan order with the center left out:
  // top left, top mid, top right, mid left, mid right,
  // bottom left, bottom mid, bottom right.
  typedef pix_t  [NBR_N-1:0] nbr_arr_t;
  typedef rank_t [NBR_N-1:0] rank_arr_t;

  typedef struct packed {
    pix_t     centre;
    nbr_arr_t nbrs;
  } win_t;

  typedef struct packed {
    pix_t             centre;
    logic             centre_black;
    nbr_arr_t         nbrs;
    logic [NBR_N-1:0] nz;
    cnt_t             count;
  } det_t;

  typedef struct packed {
    pix_t             centre;
    logic             centre_black;
    nbr_arr_t         nbrs;
    logic [NBR_N-1:0] nz;
    cnt_t             count;
    rank_arr_t        rank;
  } rnk_t;

  function automatic blue_t blue_of(pix_t px);
    return px[BLUE_W-1:0];
  endfunction

endpackage

>>> sv/hole_fill_neighbor_median_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hole_fill_neighbor_median_core
// Fills a black center pixel with the blue-median of its non-black neighbors
// when at least min_neighbors of them are non-black.
// Pipeline: an accepted input beat passes the detect, rank and select stages,
//   each one register deep, on its way to its output beat.
// Throughput: one beat per cycle; a stall at the output holds every occupied
//   stage, while empty stages ahead of it keep filling.
// Reset (rst_n low, synchronous) empties the pipeline and sets
//   min_neighbors to 1.
module hole_fill_neighbor_median_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  hfnm_pkg::min_t       cfg_min_neighbors,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hfnm_pkg::pix_t       in_top_left,
  input  hfnm_pkg::pix_t       in_top_mid,
  input  hfnm_pkg::pix_t       in_top_right,
  input  hfnm_pkg::pix_t       in_mid_left,
  input  hfnm_pkg::pix_t       in_centre_pixel,
  input  hfnm_pkg::pix_t       in_mid_right,
  input  hfnm_pkg::pix_t       in_bottom_left,
  input  hfnm_pkg::pix_t       in_bottom_mid,
  input  hfnm_pkg::pix_t       in_bottom_right,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hfnm_pkg::pix_t       out_pixel_out,
  output logic                 out_was_filled
);
  import hfnm_pkg::*;

  min_t min_r, min_nxt;
  win_t win;
  det_t det;
  rnk_t rnk;
  logic det_valid, det_ready;
  logic rnk_valid, rnk_ready;

  assign cfg_ready = 1'b1;
  assign min_nxt   = cfg_valid ? cfg_min_neighbors : min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RESET;
    end else begin
      min_r <= min_nxt;
    end
  end

  assign win.centre = in_centre_pixel;
  assign win.nbrs   = {in_bottom_right, in_bottom_mid, in_bottom_left, in_mid_right,
                       in_mid_left, in_top_right, in_top_mid, in_top_left};

  hfnm_detect u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_win    (win),
    .out_valid (det_valid),
    .out_ready (det_ready),
    .out_det   (det)
  );

  hfnm_rank u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (det_valid),
    .in_ready  (det_ready),
    .in_det    (det),
    .out_valid (rnk_valid),
    .out_ready (rnk_ready),
    .out_rnk   (rnk)
  );

  hfnm_select u_select (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (rnk_valid),
    .in_ready      (rnk_ready),
    .in_rnk        (rnk),
    .min_neighbors (min_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel_out),
    .out_filled    (out_was_filled)
  );

endmodule

>>> sv/hfnm_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfnm_detect
// First stage: flags the non-black neighbors and counts them.
// ----------------------------------------------------------------------------
module hfnm_detect (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hfnm_pkg::win_t in_win,
  output logic          out_valid,
  input  logic          out_ready,
  output hfnm_pkg::det_t out_det
);
  import hfnm_pkg::*;

  logic valid_r, valid_nxt;
  det_t det_r, det_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_det   = det_r;

  always_comb begin
    cnt_t cnt;
    cnt = '0;
    det_nxt.centre       = in_win.centre;
    det_nxt.centre_black = (in_win.centre == '0);
    det_nxt.nbrs         = in_win.nbrs;
    for (int i = 0; i < NBR_N; i++) begin
      det_nxt.nz[i] = |in_win.nbrs[i];
      cnt = cnt + cnt_t'(det_nxt.nz[i]);
    end
    det_nxt.count = cnt;
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      det_r <= det_nxt;
    end
  end

  a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ($countones(det_r.nz) == int'(det_r.count)))
    else $error("neighbor count disagrees with non-black flags");

endmodule

>>> sv/hfnm_rank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfnm_rank
// Second stage: ranks each neighbor among the non-black ones by blue value.
// ----------------------------------------------------------------------------
module hfnm_rank (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hfnm_pkg::det_t in_det,
  output logic          out_valid,
  input  logic          out_ready,
  output hfnm_pkg::rnk_t out_rnk
);
  import hfnm_pkg::*;

  logic valid_r, valid_nxt;
  rnk_t rnk_r, rnk_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_rnk   = rnk_r;

  // A neighbor j sorts ahead of i when its blue is smaller, or equal and it
  // comes earlier in scan order; that keeps the sort stable.
  always_comb begin
    rank_t r;
    logic  ahead;
    rnk_nxt.centre       = in_det.centre;
    rnk_nxt.centre_black = in_det.centre_black;
    rnk_nxt.nbrs         = in_det.nbrs;
    rnk_nxt.nz           = in_det.nz;
    rnk_nxt.count        = in_det.count;
    for (int i = 0; i < NBR_N; i++) begin
      r = '0;
      for (int j = 0; j < NBR_N; j++) begin
        ahead = 1'b0;
        if (j != i) begin
          ahead = in_det.nz[j] &&
                  ((blue_of(in_det.nbrs[j]) < blue_of(in_det.nbrs[i])) ||
                   ((blue_of(in_det.nbrs[j]) == blue_of(in_det.nbrs[i])) && (j < i)));
        end
        r = r + rank_t'(ahead);
      end
      rnk_nxt.rank[i] = r;
    end
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rnk_r <= rnk_nxt;
    end
  end

endmodule

>>> sv/hfnm_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfnm_select
// Last stage: picks the median neighbor and forms the output pixel.
// ----------------------------------------------------------------------------
module hfnm_select (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hfnm_pkg::rnk_t in_rnk,
  input  hfnm_pkg::min_t min_neighbors,
  output logic           out_valid,
  input  logic           out_ready,
  output hfnm_pkg::pix_t out_pixel,
  output logic           out_filled
);
  import hfnm_pkg::*;

  logic             valid_r, valid_nxt;
  pix_t             pixel_r, pixel_nxt;
  logic             filled_r, filled_nxt;
  logic [NBR_N-1:0] sel;
  rank_t            half;
  pix_t             median;

  assign in_ready   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_pixel  = pixel_r;
  assign out_filled = filled_r;
  assign half       = in_rnk.count[CNT_W-1:1];

  always_comb begin
    median = '0;
    for (int i = 0; i < NBR_N; i++) begin
      sel[i] = in_rnk.nz[i] && (in_rnk.rank[i] == half);
      median = median | (in_rnk.nbrs[i] & {PIX_W{sel[i]}});
    end
    filled_nxt = in_rnk.centre_black && (in_rnk.count != '0) &&
                 (in_rnk.count >= min_neighbors);
    if (!in_rnk.centre_black) begin
      pixel_nxt = in_rnk.centre;
    end else if (filled_nxt) begin
      pixel_nxt = median;
    end else begin
      pixel_nxt = '0;
    end
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pixel_r  <= pixel_nxt;
      filled_r <= filled_nxt;
    end
  end

  a_one_median: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && (in_rnk.count != '0)) |-> $onehot(sel))
    else $error("median rank not held by exactly one neighbor");

  a_fill_nonblack: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && filled_r) |-> (pixel_r != '0))
    else $error("filled hole came out black");

endmodule
